### rtl/cfd_pkg.sv
`default_nettype none

package cfd_pkg;

	// Largest payload a frame may carry
	localparam int MAX_PAYLOAD = 32;

	// Field widths
	localparam int DATA_W  = 8;
	localparam int IDX_W   = 5;
	localparam int LEN_W   = 6;
	localparam int FIELD_W = DATA_W + IDX_W + LEN_W;
	localparam int TDATA_W = ((FIELD_W + 7) / 8) * 8;
	localparam int PAD_W   = TDATA_W - FIELD_W;

	// Payload store addressing
	localparam int STORE_AW = $clog2(MAX_PAYLOAD);

	// Length byte limit
	localparam logic [DATA_W-1:0] MAX_LEN_B = DATA_W'(MAX_PAYLOAD);

	// Sync pair
	localparam logic [DATA_W-1:0] SYNC0 = 8'hAA;
	localparam logic [DATA_W-1:0] SYNC1 = 8'h55;

	// CRC16-CCITT, MSB first, no final xor
	localparam int                CRC_W    = 16;
	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;
	localparam int                CRC_BITS_STEP = 4;

	// Request to the CRC unit
	typedef struct packed {
		logic              start;
		logic              init;
		logic [DATA_W-1:0] data;
	} crc_req_t;

	// Advance the CRC register by one nibble of message bits
	function automatic logic [CRC_W-1:0] crc_nib(input logic [CRC_W-1:0] c);
		logic [CRC_W-1:0] r;
		r = c;
		for (int k = 0; k < CRC_BITS_STEP; k++) begin
			r = r[CRC_W-1] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/cfd_crc_unit.sv
`default_nettype none

module cfd_crc_unit (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire cfd_pkg::crc_req_t         req,
	output logic [cfd_pkg::CRC_W-1:0]      crc,
	output logic                           busy
);

	logic [cfd_pkg::CRC_W-1:0] crc_q;
	logic                      busy_q;
	logic [cfd_pkg::CRC_W-1:0] seed;

	// Fold the new byte into the high half of the running value
	always_comb begin
		seed = (req.init ? cfd_pkg::CRC_INIT : crc_q) ^ {req.data, {cfd_pkg::DATA_W{1'b0}}};
	end

	// Shift the high nibble on the request cycle, the low nibble on the next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= cfd_pkg::CRC_INIT;
			busy_q <= 1'b0;
		end else if (req.start) begin
			crc_q  <= cfd_pkg::crc_nib(seed);
			busy_q <= 1'b1;
		end else if (busy_q) begin
			crc_q  <= cfd_pkg::crc_nib(crc_q);
			busy_q <= 1'b0;
		end
	end

	assign crc  = crc_q;
	assign busy = busy_q;

endmodule

`default_nettype wire

### rtl/crc_checked_frame_deframer.sv
`default_nettype none

// Sync pair / type / length / payload / CRC16 deframer.
// Type, length and payload bytes feed the 4-bit-per-cycle CRC unit; s_tready is low while busy;
// sync, CRC and oversize length bytes do not start it.
// An empty-frame result appears the cycle after the high CRC byte; a payload run first enters the emit state;
// the run moves a byte per cycle while m_tready is high; s_tready is low until it drains.
// Reset clears control, the CRC to 0xFFFF and accepted type to 1; the store is not cleared.

module crc_checked_frame_deframer (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire  [cfd_pkg::DATA_W-1:0]        s_tdata,   // [7:0] rx_byte
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [cfd_pkg::TDATA_W-1:0]       m_tdata,   // [7:0] payload_byte, [12:8] byte_index,
	                                                     // [18:13] frame_length, rest zero
	output logic                              m_tuser,   // [0] empty_frame
	output logic                              m_tlast,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [cfd_pkg::DATA_W-1:0]        cfg_data   // accepted_type
);

	typedef enum logic [6:0] {
		PH_SYNC0 = 7'b0000001,
		PH_SYNC1 = 7'b0000010,
		PH_TYPE  = 7'b0000100,
		PH_LEN   = 7'b0001000,
		PH_DATA  = 7'b0010000,
		PH_CRCLO = 7'b0100000,
		PH_CRCHI = 7'b1000000
	} ph_t;

	typedef enum logic [1:0] {
		CTL_RECV = 2'b01,
		CTL_EMIT = 2'b10
	} ctl_t;

	ph_t                              phase_q;
	ctl_t                             ctl_q;
	logic [cfd_pkg::DATA_W-1:0]       acc_type_q;
	logic [cfd_pkg::DATA_W-1:0]       type_seen_q;
	logic [cfd_pkg::DATA_W-1:0]       crc_lo_q;
	logic [cfd_pkg::LEN_W-1:0]        pay_cnt_q;
	logic [cfd_pkg::LEN_W-1:0]        byte_cnt_q;
	logic [cfd_pkg::LEN_W-1:0]        byte_cnt_nxt;
	logic [cfd_pkg::LEN_W-1:0]        rd_idx_q;
	logic [cfd_pkg::LEN_W-1:0]        rd_idx_nxt;
	logic [cfd_pkg::DATA_W-1:0]       store_q [cfd_pkg::MAX_PAYLOAD];

	logic                             out_valid_q;
	logic [cfd_pkg::DATA_W-1:0]       out_pay_q;
	logic [cfd_pkg::IDX_W-1:0]        out_idx_q;
	logic [cfd_pkg::LEN_W-1:0]        out_len_q;
	logic                             out_empty_q;
	logic                             out_last_q;

	cfd_pkg::crc_req_t                crc_req;
	logic [cfd_pkg::CRC_W-1:0]        crc_val;
	logic                             crc_busy;

	logic                             in_acc;
	logic                             len_ok;
	logic                             frame_ok;
	logic                             store_wr;
	logic                             start_emit;
	logic                             empty_emit;
	logic                             load_byte;
	logic                             drained;

	cfd_crc_unit u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (crc_req),
		.crc    (crc_val),
		.busy   (crc_busy)
	);

	assign s_tready   = (ctl_q == CTL_RECV) && !crc_busy;
	assign in_acc     = s_tvalid && s_tready;
	assign len_ok     = (s_tdata <= cfd_pkg::MAX_LEN_B);
	assign frame_ok   = ({s_tdata, crc_lo_q} == crc_val) && (type_seen_q == acc_type_q);
	assign byte_cnt_nxt = byte_cnt_q + 1'b1;
	assign rd_idx_nxt   = rd_idx_q + 1'b1;

	// Decode CRC requests and store writes from the current phase
	always_comb begin
		crc_req       = '0;
		crc_req.data  = s_tdata;
		store_wr      = 1'b0;
		case (phase_q)
			PH_TYPE: begin
				crc_req.start = in_acc;
				crc_req.init  = 1'b1;
			end
			PH_LEN: begin
				crc_req.start = in_acc && len_ok;
			end
			PH_DATA: begin
				crc_req.start = in_acc;
				store_wr      = in_acc &&
					(byte_cnt_q < cfd_pkg::LEN_W'(cfd_pkg::MAX_PAYLOAD));
			end
			default: begin
				crc_req.start = 1'b0;
			end
		endcase
	end

	// Result run control
	assign start_emit = in_acc && (phase_q == PH_CRCHI) && frame_ok;
	assign empty_emit = start_emit && (pay_cnt_q == '0);
	assign load_byte  = (ctl_q == CTL_EMIT) && (rd_idx_q != pay_cnt_q) &&
		(!out_valid_q || m_tready);
	assign drained    = (ctl_q == CTL_EMIT) && (rd_idx_q == pay_cnt_q) &&
		(!out_valid_q || m_tready);

	// Hold the accepted type register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_type_q <= cfd_pkg::DATA_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			acc_type_q <= cfg_data;
		end
	end

	// Advance the frame parser on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SYNC0;
			type_seen_q <= '0;
			pay_cnt_q   <= '0;
			byte_cnt_q  <= '0;
			crc_lo_q    <= '0;
		end else if (in_acc) begin
			case (phase_q)
				PH_SYNC0: begin
					if (s_tdata == cfd_pkg::SYNC0) phase_q <= PH_SYNC1;
				end
				PH_SYNC1: begin
					if (s_tdata == cfd_pkg::SYNC1) begin
						phase_q <= PH_TYPE;
					end else if (s_tdata != cfd_pkg::SYNC0) begin
						phase_q <= PH_SYNC0;
					end
				end
				PH_TYPE: begin
					type_seen_q <= s_tdata;
					phase_q     <= PH_LEN;
				end
				PH_LEN: begin
					if (!len_ok) begin
						phase_q <= PH_SYNC0;
					end else begin
						pay_cnt_q  <= s_tdata[cfd_pkg::LEN_W-1:0];
						byte_cnt_q <= '0;
						phase_q    <= (s_tdata == '0) ? PH_CRCLO : PH_DATA;
					end
				end
				PH_DATA: begin
					byte_cnt_q <= byte_cnt_nxt;
					if (byte_cnt_nxt >= pay_cnt_q) phase_q <= PH_CRCLO;
				end
				PH_CRCLO: begin
					crc_lo_q <= s_tdata;
					phase_q  <= PH_CRCHI;
				end
				PH_CRCHI: begin
					phase_q <= PH_SYNC0;
				end
				default: begin
					phase_q <= PH_SYNC0;
				end
			endcase
		end
	end

	// Write payload bytes into the store
	always_ff @(posedge clk) begin
		if (store_wr) begin
			store_q[byte_cnt_q[cfd_pkg::STORE_AW-1:0]] <= s_tdata;
		end
	end

	// Sequence the result run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q       <= CTL_RECV;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (start_emit) begin
				ctl_q    <= CTL_EMIT;
				rd_idx_q <= '0;
			end else if (drained) begin
				ctl_q <= CTL_RECV;
			end else if (load_byte) begin
				rd_idx_q <= rd_idx_nxt;
			end
			if (load_byte || empty_emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the output register from the store, or with the empty-frame result
	always_ff @(posedge clk) begin
		if (load_byte) begin
			out_pay_q   <= store_q[rd_idx_q[cfd_pkg::STORE_AW-1:0]];
			out_idx_q   <= rd_idx_q[cfd_pkg::IDX_W-1:0];
			out_len_q   <= pay_cnt_q;
			out_empty_q <= 1'b0;
			out_last_q  <= (rd_idx_nxt == pay_cnt_q);
		end else if (empty_emit) begin
			out_pay_q   <= '0;
			out_idx_q   <= '0;
			out_len_q   <= '0;
			out_empty_q <= 1'b1;
			out_last_q  <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{cfd_pkg::PAD_W{1'b0}}, out_len_q, out_idx_q, out_pay_q};
	assign m_tuser  = out_empty_q;
	assign m_tlast  = out_last_q;

`ifndef ASSERT_OFF
	a_no_input_during_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input taken while a result is pending");

	a_run_ends_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
		else $error("result presented after the last of a run");

	a_empty_result_form: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tlast && (m_tdata[cfd_pkg::DATA_W-1:0] == '0)))
		else $error("empty-frame result is malformed");

	a_crc_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && crc_req.start) |=> !s_tready)
		else $error("input taken while the CRC unit is busy");
`endif

endmodule

`default_nettype wire

### dv/deframe_checker.sv
`timescale 1ns / 100ps

module deframe_checker (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	input  wire                          s_tready,
	input  wire  [cfd_pkg::DATA_W-1:0]  s_tdata,   // [7:0] rx_byte
	input  wire                          m_tvalid,
	input  wire                          m_tready,
	input  wire  [cfd_pkg::TDATA_W-1:0] m_tdata,   // [7:0] payload_byte, [12:8] byte_index,
	                                               // [18:13] frame_length, rest zero
	input  wire                          m_tuser,   // [0] empty_frame
	input  wire                          m_tlast,
	input  wire                          cfg_valid,
	input  wire                          cfg_ready,
	input  wire  [cfd_pkg::DATA_W-1:0]  cfg_data,  // accepted_type
	output int                           fail_count,
	output int                           pending,
	output int                           bytes_in,
	output int                           frames_out,
	output int                           beats_out
);

	typedef enum logic [6:0] {
		HUNT_SYNC0 = 7'b0000001,
		HUNT_SYNC1 = 7'b0000010,
		GET_TYPE   = 7'b0000100,
		GET_LEN    = 7'b0001000,
		GET_DATA   = 7'b0010000,
		GET_CRC_LO = 7'b0100000,
		GET_CRC_HI = 7'b1000000
	} hunt_t;

	typedef struct packed {
		logic [cfd_pkg::DATA_W-1:0] data;
		logic [cfd_pkg::IDX_W-1:0]  idx;
		logic [cfd_pkg::LEN_W-1:0]  len;
		logic                       empty;
		logic                       last;
	} beat_t;

	// Predicted deframer state
	hunt_t                      phase;
	logic [cfd_pkg::DATA_W-1:0] accept_type;
	logic [cfd_pkg::DATA_W-1:0] type_seen;
	logic [cfd_pkg::LEN_W-1:0]  pay_len;
	logic [cfd_pkg::LEN_W-1:0]  wr_ptr;
	logic [cfd_pkg::CRC_W-1:0]  crc_acc;
	logic [cfd_pkg::DATA_W-1:0] crc_lo;
	logic [cfd_pkg::DATA_W-1:0] store [cfd_pkg::MAX_PAYLOAD];

	// Output beats still owed by the block, oldest first
	beat_t due_beats [$];

	// CRC16-CCITT over one byte, MSB first
	function automatic logic [cfd_pkg::CRC_W-1:0] ccitt_byte(
			input logic [cfd_pkg::CRC_W-1:0] c, input logic [cfd_pkg::DATA_W-1:0] b);
		logic [cfd_pkg::CRC_W-1:0] r;
		int                        k;
		r = c ^ {b, 8'h00};
		for (k = 0; k < 8; k++) begin
			r = r[cfd_pkg::CRC_W-1] ? ((r << 1) ^ cfd_pkg::CRC_POLY) : (r << 1);
		end
		return r;
	endfunction

	// Advance the frame hunt by one link byte and queue any payload run
	task automatic absorb_link_byte(input logic [cfd_pkg::DATA_W-1:0] b);
		beat_t bt;
		int    i;
		case (phase)
			HUNT_SYNC0: begin
				if (b == cfd_pkg::SYNC0)
					phase = HUNT_SYNC1;
			end
			HUNT_SYNC1: begin
				if (b == cfd_pkg::SYNC1)
					phase = GET_TYPE;
				else if (b != cfd_pkg::SYNC0)
					phase = HUNT_SYNC0;
			end
			GET_TYPE: begin
				type_seen = b;
				crc_acc = ccitt_byte(cfd_pkg::CRC_INIT, b);
				phase = GET_LEN;
			end
			GET_LEN: begin
				// drop oversize frames at once
				if (b > cfd_pkg::MAX_LEN_B) begin
					phase = HUNT_SYNC0;
				end else begin
					pay_len = b[cfd_pkg::LEN_W-1:0];
					wr_ptr = '0;
					crc_acc = ccitt_byte(crc_acc, b);
					phase = (b == 0) ? GET_CRC_LO : GET_DATA;
				end
			end
			GET_DATA: begin
				store[wr_ptr[cfd_pkg::STORE_AW-1:0]] = b;
				crc_acc = ccitt_byte(crc_acc, b);
				wr_ptr = wr_ptr + 1'b1;
				if (wr_ptr >= pay_len)
					phase = GET_CRC_LO;
			end
			GET_CRC_LO: begin
				crc_lo = b;
				phase = GET_CRC_HI;
			end
			GET_CRC_HI: begin
				if ({b, crc_lo} == crc_acc && type_seen == accept_type) begin
					frames_out++;
					if (pay_len == 0) begin
						bt = '{data: '0, idx: '0, len: '0, empty: 1'b1, last: 1'b1};
						due_beats.push_back(bt);
					end else begin
						for (i = 0; i < pay_len; i++) begin
							bt.data  = store[i];
							bt.idx   = i[cfd_pkg::IDX_W-1:0];
							bt.len   = pay_len;
							bt.empty = 1'b0;
							bt.last  = (i + 1 == pay_len);
							due_beats.push_back(bt);
						end
					end
				end
				phase = HUNT_SYNC0;
			end
			default: phase = HUNT_SYNC0;
		endcase
	endtask

	task automatic check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
		end
	endtask

	// Track config, predict from accepted bytes, compare accepted results
	always @(posedge clk or negedge arst_n) begin
		beat_t want;
		if (!arst_n) begin
			phase       = HUNT_SYNC0;
			accept_type = 8'h01;
			type_seen   = '0;
			pay_len     = '0;
			wr_ptr      = '0;
			crc_acc     = cfd_pkg::CRC_INIT;
			crc_lo      = '0;
			due_beats.delete();
			fail_count  = 0;
			bytes_in    = 0;
			frames_out  = 0;
			beats_out   = 0;
			pending    <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				accept_type = cfg_data;
			if (s_tvalid && s_tready) begin
				bytes_in++;
				absorb_link_byte(s_tdata);
			end
			if (m_tvalid && m_tready) begin
				beats_out++;
				if (due_beats.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result: expected none, actual %h/%b/%b",
						$time, m_tdata, m_tuser, m_tlast);
				end else begin
					want = due_beats.pop_front();
					check_field("payload_byte", want.data, m_tdata[cfd_pkg::DATA_W-1:0]);
					check_field("byte_index", want.idx,
						m_tdata[cfd_pkg::DATA_W +: cfd_pkg::IDX_W]);
					check_field("frame_length", want.len,
						m_tdata[cfd_pkg::DATA_W+cfd_pkg::IDX_W +: cfd_pkg::LEN_W]);
					check_field("tdata padding", 0,
						m_tdata[cfd_pkg::TDATA_W-1:cfd_pkg::FIELD_W]);
					check_field("empty_frame", want.empty, m_tuser);
					check_field("last", want.last, m_tlast);
				end
			end
			pending <= due_beats.size();
		end
	end

endmodule

### dv/tb_crc_checked_frame_deframer.sv
`timescale 1ns / 100ps

module tb_crc_checked_frame_deframer;

	localparam int NUM_PHASES    = 6;
	localparam int PHASE_BYTES   = 56;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 400;
	localparam int QUIET_LIMIT   = 4000;

	logic                         clk      = 1'b0;
	logic                         arst_n   = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [cfd_pkg::DATA_W-1:0]   s_tdata  = '0;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [cfd_pkg::TDATA_W-1:0]  m_tdata;
	logic                         m_tuser;
	logic                         m_tlast;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [cfd_pkg::DATA_W-1:0]   cfg_data  = '0;

	int fail_count;
	int pending;
	int bytes_in;
	int frames_out;
	int beats_out;

	// Stimulus control shared with the receiver
	bit                         tx_idle_on  = 1'b0;
	bit                         rx_idle_on  = 1'b0;
	bit                         hold_req    = 1'b0;
	logic [cfd_pkg::DATA_W-1:0] acc_now     = 8'h01;
	logic [cfd_pkg::DATA_W-1:0] pay_q [$];
	int                         phase_bytes = 0;
	int                         quiet_cycles = 0;
	int                         p;

	crc_checked_frame_deframer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	deframe_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending),
		.bytes_in   (bytes_in),
		.frames_out (frames_out),
		.beats_out  (beats_out)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Receiver: random back-pressure bursts, one long hold-off on request
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 4)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Abort when no channel moves a request for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: watchdog: %0d cycles without a handshake", $time, quiet_cycles);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	function automatic logic [cfd_pkg::CRC_W-1:0] frame_crc_step(
			input logic [cfd_pkg::CRC_W-1:0] c, input logic [cfd_pkg::DATA_W-1:0] b);
		logic [cfd_pkg::CRC_W-1:0] r;
		int                        k;
		r = c ^ {b, 8'h00};
		for (k = 0; k < 8; k++) begin
			r = r[cfd_pkg::CRC_W-1] ? ((r << 1) ^ cfd_pkg::CRC_POLY) : (r << 1);
		end
		return r;
	endfunction

	// Mostly short payloads, now and then long or full size
	function automatic int pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(0, 8);
		else if (r < 92)
			return $urandom_range(9, cfd_pkg::MAX_PAYLOAD - 1);
		return cfd_pkg::MAX_PAYLOAD;
	endfunction

	// Offer one link byte, with an optional idle burst ahead of it
	task automatic push_byte(input logic [cfd_pkg::DATA_W-1:0] b);
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		phase_bytes++;
	endtask

	task automatic fill_payload(input int len);
		int r;
		int i;
		pay_q.delete();
		for (i = 0; i < len; i++) begin
			r = $urandom_range(0, 9);
			if (r == 0)
				pay_q.push_back(cfd_pkg::SYNC0);
			else if (r == 1)
				pay_q.push_back(cfd_pkg::SYNC1);
			else
				pay_q.push_back(cfd_pkg::DATA_W'($urandom_range(0, 255)));
		end
	endtask

	// Send sync, type, length, pay_q and the CRC xored with flip
	task automatic send_frame(input logic [cfd_pkg::DATA_W-1:0] ftype,
			input logic [cfd_pkg::CRC_W-1:0] flip);
		logic [cfd_pkg::CRC_W-1:0]  c;
		logic [cfd_pkg::DATA_W-1:0] n;
		int                         i;
		n = cfd_pkg::DATA_W'(pay_q.size());
		c = frame_crc_step(cfd_pkg::CRC_INIT, ftype);
		c = frame_crc_step(c, n);
		push_byte(cfd_pkg::SYNC0);
		push_byte(cfd_pkg::SYNC1);
		push_byte(ftype);
		push_byte(n);
		for (i = 0; i < pay_q.size(); i++) begin
			c = frame_crc_step(c, pay_q[i]);
			push_byte(pay_q[i]);
		end
		c = c ^ flip;
		push_byte(c[7:0]);
		push_byte(c[15:8]);
	endtask

	// Drop the valid, wait for all owed results and let the block go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_type(input logic [cfd_pkg::DATA_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		acc_now = v;
	endtask

	// Mixed traffic: mostly good frames, plus drops, broken frames and noise
	task automatic run_traffic();
		int kind;
		int len;
		int i;
		while (phase_bytes < PHASE_BYTES) begin
			kind = $urandom_range(0, 99);
			if (kind < 60) begin
				fill_payload(pick_len());
				send_frame(acc_now, '0);
			end else if (kind < 68) begin
				fill_payload(pick_len());
				send_frame(acc_now ^ cfd_pkg::DATA_W'($urandom_range(1, 255)), '0);
			end else if (kind < 76) begin
				fill_payload(pick_len());
				send_frame(acc_now, cfd_pkg::CRC_W'($urandom_range(1, 65535)));
			end else if (kind < 82) begin
				push_byte(cfd_pkg::SYNC0);
				push_byte(cfd_pkg::SYNC1);
				push_byte(acc_now);
				push_byte(cfd_pkg::DATA_W'($urandom_range(cfd_pkg::MAX_PAYLOAD + 1, 255)));
			end else if (kind < 88) begin
				repeat ($urandom_range(1, 3)) push_byte(cfd_pkg::SYNC0);
				fill_payload(pick_len());
				send_frame(acc_now, '0);
			end else if (kind < 94) begin
				len = $urandom_range(1, 8);
				push_byte(cfd_pkg::SYNC0);
				push_byte(cfd_pkg::SYNC1);
				push_byte(acc_now);
				push_byte(cfd_pkg::DATA_W'(len));
				for (i = 0; i < $urandom_range(0, len); i++)
					push_byte(cfd_pkg::DATA_W'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 6))
					push_byte(cfd_pkg::DATA_W'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames under the reset type
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		// repeated first sync byte, then an empty frame
		push_byte(cfd_pkg::SYNC0);
		pay_q.delete();
		send_frame(8'h01, '0);
		// sync values carried inside the payload
		pay_q.delete();
		pay_q.push_back(cfd_pkg::SYNC0);
		pay_q.push_back(cfd_pkg::SYNC1);
		send_frame(8'h01, '0);
		// length one above the limit
		push_byte(cfd_pkg::SYNC0);
		push_byte(cfd_pkg::SYNC1);
		push_byte(8'h01);
		push_byte(cfd_pkg::DATA_W'(cfd_pkg::MAX_PAYLOAD + 1));
		// bad CRC
		pay_q.delete();
		pay_q.push_back(8'h00);
		send_frame(8'h01, 16'h0100);

		for (p = 0; p < NUM_PHASES; p++) begin
			settle();
			case (p)
				0: write_type(8'h00);
				1: write_type(8'hFF);
				4: write_type(8'h01);
				default: write_type(cfd_pkg::DATA_W'($urandom_range(0, 255)));
			endcase
			tx_idle_on = (p != 2) && (p != NUM_PHASES - 1);
			rx_idle_on = (p != NUM_PHASES - 1);
			phase_bytes = 0;
			if (p == 1) begin
				// hold the receiver while a short frame and a full-size frame are sent
				hold_req = 1'b1;
				fill_payload(8);
				send_frame(acc_now, '0);
				fill_payload(cfd_pkg::MAX_PAYLOAD);
				send_frame(acc_now, '0);
			end
			run_traffic();
		end
		settle();

		$display("covered %0d link bytes under %0d type settings, %0d frames delivered",
			bytes_in, NUM_PHASES + 1, frames_out);
		$display("checked %0d result beats, with drops, broken frames and a long output stall",
			beats_out);
		if (fail_count == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### crc_checked_frame_deframer.f
rtl/cfd_pkg.sv
rtl/cfd_crc_unit.sv
rtl/crc_checked_frame_deframer.sv
dv/deframe_checker.sv
dv/tb_crc_checked_frame_deframer.sv
